// ===== rtl/ple_pkg.sv =====
// ple_pkg: shared constants, types and helpers of the positional list engine
`timescale 1ns / 1ps

package ple_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned CNT_OUT_W = 5;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W     = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_REMOVE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_FINISH
  } state_e;

  typedef struct packed {
    action_e                  action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    status_e                  status;
    logic [CNT_OUT_W-1:0]     count;
    logic                     is_empty;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr;
  } ram_req_t;

  // 1-based position to 0-based storage index
  function automatic logic [AW-1:0] pos_to_slot(input logic [POS_W-1:0] pos);
    logic [CMP_W-1:0] t;
    t = CMP_W'(pos) - CMP_W'(1);
    return t[AW-1:0];
  endfunction

endpackage

// ===== rtl/ple_ram.sv =====
// ple_ram: generic simple dual-port ram, one write port, one registered read port
`timescale 1ns / 1ps

module ple_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ple_ctrl.sv =====
// ple_ctrl: request sequencer, entry count and shift engine over the list ram
`timescale 1ns / 1ps

module ple_ctrl import ple_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  req_t              req_i,
  output ram_req_t          ram_o,
  input  logic [DATA_W-1:0] rdata_i,
  output logic              done_o,
  output rsp_t              rsp_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  action_e           act_q, act_d;
  status_e           status_q, status_d;
  logic [AW-1:0]     slot_q, slot_d;
  logic [AW-1:0]     wr_q, wr_d;
  logic [DATA_W-1:0] val_q, val_d;

  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  cnt_c;
  logic [AW-1:0]     slot_c;

  assign pos_c  = CMP_W'(req_i.position);
  assign cnt_c  = CMP_W'(count_q);
  assign slot_c = pos_to_slot(req_i.position);
  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    wr_q     <= wr_d;
    val_q    <= val_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    act_d       = act_q;
    status_d    = status_q;
    slot_d      = slot_q;
    wr_d        = wr_q;
    val_d       = val_q;
    ram_o.we    = 1'b0;
    ram_o.waddr = wr_q;
    ram_o.wdata = rdata_i;
    ram_o.raddr = slot_c;
    done_o      = 1'b0;
    rsp_o.read_value = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          act_d   = req_i.action;
          val_d   = req_i.value;
          slot_d  = slot_c;
          state_d = S_FINISH;
          if (req_i.action == ACT_INSERT) begin
            if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1)) begin
              status_d = ST_BADPOS;
            end else if (cnt_c >= CMP_W'(DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              status_d = ST_OK;
              // not an append: move the tail up one place first
              if (pos_c <= cnt_c) begin
                ram_o.raddr = AW'(count_q - CNT_W'(1));
                wr_d        = AW'(count_q);
                state_d     = S_SHIFT_UP;
              end
            end
          end else if (pos_c == '0 || pos_c > cnt_c) begin
            status_d = ST_BADPOS;
          end else begin
            status_d = ST_OK;
            if (req_i.action == ACT_REMOVE && pos_c < cnt_c) begin
              ram_o.raddr = slot_c + AW'(1);
              wr_d        = slot_c;
              state_d     = S_SHIFT_DN;
            end
          end
        end
      end

      S_SHIFT_UP: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = wr_q;
        ram_o.wdata = rdata_i;
        if ((wr_q - AW'(1)) == slot_q) begin
          state_d = S_FINISH;
        end else begin
          ram_o.raddr = wr_q - AW'(2);
          wr_d        = wr_q - AW'(1);
        end
      end

      S_SHIFT_DN: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = wr_q;
        ram_o.wdata = rdata_i;
        if (CMP_W'(wr_q) + CMP_W'(2) >= cnt_c) begin
          state_d = S_FINISH;
        end else begin
          ram_o.raddr = wr_q + AW'(2);
          wr_d        = wr_q + AW'(1);
        end
      end

      S_FINISH: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
        if (status_q == ST_OK) begin
          unique case (act_q)
            ACT_READ: begin
              rsp_o.read_value = rdata_i;
            end
            ACT_WRITE: begin
              ram_o.we    = 1'b1;
              ram_o.waddr = slot_q;
              ram_o.wdata = val_q;
            end
            ACT_INSERT: begin
              ram_o.we    = 1'b1;
              ram_o.waddr = slot_q;
              ram_o.wdata = val_q;
              count_d     = count_q + CNT_W'(1);
            end
            ACT_REMOVE: begin
              count_d = count_q - CNT_W'(1);
            end
          endcase
        end
      end
    endcase

    rsp_o.status   = status_q;
    rsp_o.count    = CNT_OUT_W'(count_d);
    rsp_o.is_empty = (count_d == '0);
  end

endmodule

// ===== rtl/positional_list_engine.sv =====
// positional_list_engine: top level, ordered list of signed entries in a ram
`timescale 1ns / 1ps
// flow: an accepted request ends in S_FINISH, which loads the result register behind rsp_o;
//   read, write, append, tail remove and errors go there directly, while a middle insert
//   or remove first shifts the tail in S_SHIFT_UP or S_SHIFT_DN, through the single ram
//   write port that moves one entry per cycle; no new request is taken while busy
// reset: rst_ni clears the count and the sequencer, list contents stay undefined;
//   the receiver cannot stall, each result shows for one cycle with rsp_valid_o

module positional_list_engine import ple_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  // sequencer <-> ram
  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;

  // finished request from the sequencer, registered before it shows on the ports
  logic done;
  rsp_t rsp_d;

  logic rsp_valid_q;
  rsp_t rsp_q;

  // list storage, entry k holds list position k+1
  ple_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // request decode, range checks, count and entry shifting
  ple_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .req_i   (req_i),
    .ram_o   (ram_req),
    .rdata_i (ram_rdata),
    .done_o  (done),
    .rsp_o   (rsp_d)
  );

  // result register: the strobe is a flop, the payload is loaded only on done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // an accepted request always occupies the sequencer for the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  // the result appears as the sequencer returns to idle
  a_rsp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy)
    else $error("result strobe while still busy");

  // every request passes through idle before S_FINISH, so strobes never abut
  a_rsp_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o)
    else $error("two result strobes in a row");

  // a full-list status only when the list really holds every entry
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == ST_FULL) |-> (rsp_o.count == CNT_OUT_W'(DEPTH)))
    else $error("full status with a count below capacity");

endmodule

// ===== verif/positional_list_engine_test.sv =====
// positional_list_engine_test: self-checking bench for the positional list engine
`timescale 1ns / 1ps

module positional_list_engine_test;
  import ple_pkg::*;

  // one queued request, optionally held back until the engine has drained
  typedef struct {
    req_t req;
    bit   drain;
  } pend_item_t;

  logic clk_i;
  logic rst_ni;
  logic req_start = 1'b0;
  logic req_busy;
  req_t req_bus   = '0;
  logic rsp_strobe;
  rsp_t rsp_bus;

  positional_list_engine uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (req_start),
    .busy       (req_busy),
    .req_i      (req_bus),
    .rsp_valid_o(rsp_strobe),
    .rsp_o      (rsp_bus)
  );

  // requests waiting to be driven, filled up front by the stimulus block
  pend_item_t pending[$];
  // responses predicted for accepted requests, oldest first
  rsp_t       expected_rsp[$];

  // shadow copy of the list as the engine should hold it
  logic signed [DATA_W-1:0] list_mem [DEPTH];
  int                       list_len;

  int  sent_total;   // requests accepted, updated only by the driver
  int  rcv_total;    // responses seen, updated only by the monitor (nonblocking)
  int  error_count;
  int  gen_len;      // list length as tracked while building the stimulus
  logic drv_fire;

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // hard stop in case the engine hangs or drops responses
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor: applies one request to the shadow list, returns the response
  // ---------------------------------------------------------------------------
  function automatic rsp_t apply_list_op(input req_t r);
    rsp_t o;
    int   pos;
    int   slot;
    o        = '0;
    o.status = ST_OK;
    pos      = int'(r.position);
    slot     = pos - 1;
    if (r.action == ACT_INSERT) begin
      // bad position wins over a full list
      if (pos == 0 || pos > list_len + 1) begin
        o.status = ST_BADPOS;
      end else if (list_len >= int'(DEPTH)) begin
        o.status = ST_FULL;
      end else begin
        for (int i = list_len; i > slot; i--) list_mem[i] = list_mem[i-1];
        list_mem[slot] = r.value;
        list_len++;
      end
    end else if (pos == 0 || pos > list_len) begin
      o.status = ST_BADPOS;
    end else begin
      case (r.action)
        ACT_READ: begin
          o.read_value = list_mem[slot];
        end
        ACT_WRITE: begin
          list_mem[slot] = r.value;
        end
        default: begin
          // remove closes the gap
          for (int i = slot; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      endcase
    end
    o.count    = CNT_OUT_W'(list_len);
    o.is_empty = (list_len == 0);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one request per handshake, random gaps, optional drain hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_start  <= 1'b0;
      req_bus    <= '0;
      sent_total  = 0;
      list_len    = 0;
    end else begin
      drv_fire = req_start && !req_busy;
      if (drv_fire) begin
        expected_rsp.push_back(apply_list_op(req_bus));
        sent_total++;
      end
      if (req_start && !drv_fire) begin
        // engine busy, keep the request on the bus
      end else if (pending.size() == 0) begin
        req_start <= 1'b0;
      end else if (pending[0].drain && sent_total != rcv_total) begin
        // hold off until every outstanding response is back
        req_start <= 1'b0;
      end else if ((sent_total < 700 || sent_total > 1100) && $urandom_range(0, 99) < 7) begin
        // random sender gap, none inside the quiet stretch
        req_start <= 1'b0;
      end else begin
        req_start <= 1'b1;
        req_bus   <= pending.pop_front().req;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every strobe is checked against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_total   <= 0;
      error_count  = 0;
    end else if (rsp_strobe) begin
      rcv_total <= rcv_total + 1;
      if (expected_rsp.size() == 0) begin
        $error("unexpected response: read_value %0d status %0d count %0d",
               rsp_bus.read_value, rsp_bus.status, rsp_bus.count);
        error_count++;
      end else begin
        if (rsp_bus.read_value !== expected_rsp[0].read_value) begin
          $error("read_value mismatch: expected %0d, actual %0d",
                 expected_rsp[0].read_value, rsp_bus.read_value);
          error_count++;
        end
        if (rsp_bus.status !== expected_rsp[0].status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 expected_rsp[0].status, rsp_bus.status);
          error_count++;
        end
        if (rsp_bus.count !== expected_rsp[0].count) begin
          $error("count mismatch: expected %0d, actual %0d",
                 expected_rsp[0].count, rsp_bus.count);
          error_count++;
        end
        if (rsp_bus.is_empty !== expected_rsp[0].is_empty) begin
          $error("is_empty mismatch: expected %0d, actual %0d",
                 expected_rsp[0].is_empty, rsp_bus.is_empty);
          error_count++;
        end
        void'(expected_rsp.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus building, length tracked so most positions land in range
  // ---------------------------------------------------------------------------
  task automatic queue_req(input action_e act, input int pos, input logic [DATA_W-1:0] val,
                           input bit drain);
    pend_item_t p;
    p.req.action   = act;
    p.req.position = POS_W'(pos);
    p.req.value    = val;
    p.drain        = drain;
    pending.push_back(p);
    if (act == ACT_INSERT) begin
      if (pos >= 1 && pos <= gen_len + 1 && gen_len < int'(DEPTH)) gen_len++;
    end else if (act == ACT_REMOVE) begin
      if (pos >= 1 && pos <= gen_len) gen_len--;
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int      mode;
    int      roll;
    int      pos;
    action_e act;
    bit      drain;

    gen_len = 0;

    // directed: accesses on an empty list are all bad positions
    queue_req(ACT_READ,   1, 32'h1234_5678, 1'b0);
    queue_req(ACT_REMOVE, 0, 32'h0,         1'b0);
    queue_req(ACT_WRITE,  1, 32'hDEAD_BEEF, 1'b0);
    queue_req(ACT_INSERT, 0, 32'h1,         1'b0);
    queue_req(ACT_INSERT, 2, 32'h2,         1'b0);
    // build a short list: first entry, append, head insert, middle insert
    queue_req(ACT_INSERT, 1, 32'h7FFF_FFFF, 1'b0);
    queue_req(ACT_INSERT, 2, 32'h8000_0000, 1'b0);
    queue_req(ACT_INSERT, 1, 32'hFFFF_FFFF, 1'b0);
    queue_req(ACT_INSERT, 2, 32'h0000_0000, 1'b0);
    for (int i = 1; i <= 4; i++) queue_req(ACT_READ, i, 32'hA5A5_A5A5, 1'b0);
    // write at the last entry and one past it
    queue_req(ACT_WRITE,  4, 32'h5555_5555, 1'b0);
    queue_req(ACT_WRITE,  5, 32'hAAAA_AAAA, 1'b0);
    queue_req(ACT_READ,   4, 32'h0,         1'b0);
    queue_req(ACT_READ,  31, 32'h0,         1'b0);
    queue_req(ACT_INSERT, 31, 32'h3,        1'b0);
    // middle remove, tail remove, then a remove one past the end
    queue_req(ACT_REMOVE, 2, 32'h0,         1'b0);
    queue_req(ACT_REMOVE, 3, 32'h0,         1'b0);
    queue_req(ACT_REMOVE, 3, 32'h0,         1'b0);
    queue_req(ACT_READ,   2, 32'h0,         1'b0);

    // random: phases that grow, shrink or churn the list, so full and empty
    // lists both come up; most requests valid, the rest random positions
    for (int n = 0; n < 1930; n++) begin
      if (n % 120 == 0) mode = $urandom_range(0, 2);
      drain = (n % 250 == 249);
      roll  = $urandom_range(0, 99);
      case (mode)
        0: act = (roll < 55) ? ACT_INSERT : (roll < 70) ? ACT_REMOVE :
                 (roll < 85) ? ACT_READ : ACT_WRITE;
        1: act = (roll < 55) ? ACT_REMOVE : (roll < 70) ? ACT_INSERT :
                 (roll < 85) ? ACT_READ : ACT_WRITE;
        default: act = action_e'(2'(roll % 4));
      endcase
      if ($urandom_range(0, 99) < 15) begin
        pos = $urandom_range(0, 31);
      end else begin
        if (gen_len == 0 && act != ACT_INSERT) act = ACT_INSERT;
        if (act == ACT_INSERT) pos = $urandom_range(1, gen_len + 1);
        else pos = $urandom_range(1, gen_len);
      end
      queue_req(act, pos, pick_value(), drain);
    end

    // wait for every request to go out and every response to come back
    while (pending.size() != 0 || req_start || rcv_total != sent_total) @(negedge clk_i);
    // allow any late or stray response to show up
    repeat (40) @(negedge clk_i);
    if (expected_rsp.size() != 0) begin
      $error("%0d predicted responses never arrived", expected_rsp.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
